[design/cgpd_pkg.sv]
// Shared types and constants for the character generator port decoder.
// No dependencies; used by cgpd_decode and char_generator_port_decoder.
`timescale 1ns / 1ps

package cgpd_pkg;

   // bus access operation codes
   typedef enum logic [2:0] {
      OP_CODE_HIGH = 3'd0,
      OP_CODE_LOW  = 3'd1,
      OP_LINE      = 3'd2,
      OP_PAT_WRITE = 3'd3,
      OP_PAT_READ  = 3'd4
   } opcode_type;

   // font memory request codes
   typedef enum logic [1:0] {
      ACC_NONE  = 2'd0,
      ACC_READ  = 2'd1,
      ACC_WRITE = 2'd2
   } access_type;

   // configuration register indexes
   localparam logic CSR_CHIP_LEVEL = 1'b0;
   localparam logic CSR_MODE_BIT   = 1'b1;

   // address map constants
   localparam logic [19:0] NO_WINDOW    = 20'h7fff0;
   localparam logic [19:0] ANK_BASE     = 20'h80000;
   localparam logic [19:0] MODE_OFFSET  = 20'h02000;
   localparam logic [19:0] HALF_OFFSET  = 20'h00800;
   localparam logic [1:0]  WINDOW_LEVEL = 2'd2;
   localparam logic [5:0]  USER_CODE    = 6'h2b;   // code bits 6..1 of 0x56/0x57
   localparam logic [6:0]  USER_LO      = 7'h56;
   localparam logic [6:0]  USER_HI      = 7'h58;
   localparam logic [6:0]  SEMI_LO      = 7'h0c;
   localparam logic [6:0]  SEMI_HI      = 7'h10;
   localparam logic [6:0]  GAP_LO       = 7'h08;
   localparam logic [6:0]  RSV_HI       = 7'h60;

   // kept state of the port
   typedef struct packed {
      logic [15:0] char_code;
      logic [3:0]  line_index;
      logic        right_half;
      logic        written_mark;
   } port_state_type;

   // one result word
   typedef struct packed {
      logic [1:0]  font_access;
      logic [19:0] font_addr;
      logic [7:0]  font_wdata;
      logic [18:0] window_low;
      logic [19:0] window_high;
      logic        window_writable;
      logic        pattern_written;
   } result_type;

endpackage

[design/cgpd_decode.sv]
// Combinational next state and result word for one bus access.
// Depends on cgpd_pkg.
`timescale 1ns / 1ps

module cgpd_decode import cgpd_pkg::*; (
   input  port_state_type state,
   input  logic [1:0]     chip_level,
   input  logic           mode_bit,
   input  logic [2:0]     opcode,
   input  logic [7:0]     data_byte,
   output port_state_type next_state,
   output result_type     result
);

   logic [15:0] code;
   logic [19:0] kanji_base;
   logic [19:0] half_add;
   logic [19:0] kanji_addr;
   logic [19:0] ank_addr;
   logic [6:0]  cls;
   logic [19:0] win_low;
   logic [19:0] win_high;
   logic        writable;
   logic [1:0]  font_access;
   logic [19:0] font_addr;
   logic [7:0]  font_wdata;

   // state update and font request
   always_comb begin
      next_state  = state;
      font_access = ACC_NONE;
      font_addr   = '0;
      font_wdata  = '0;
      case (opcode)
         OP_CODE_HIGH: next_state.char_code = {data_byte, state.char_code[7:0]};
         OP_CODE_LOW:  next_state.char_code = {state.char_code[15:8], data_byte};
         OP_LINE: begin
            next_state.line_index = data_byte[3:0];
            next_state.right_half = ~data_byte[5];
         end
         OP_PAT_WRITE: begin
            if (state.char_code[6:1] == USER_CODE) begin
               font_access             = ACC_WRITE;
               font_addr               = kanji_addr;
               font_wdata              = data_byte;
               next_state.written_mark = 1'b1;
            end
         end
         OP_PAT_READ: begin
            font_access = ACC_READ;
            font_addr   = (state.char_code[15:8] != 8'h00) ? kanji_addr : ank_addr;
         end
         default: ;
      endcase
   end

   // addresses from the current code and line (ops that use them leave both alone)
   assign kanji_base = {1'b0, state.char_code[14:8], 1'b0, state.char_code[6:0], 4'b0000};
   assign half_add   = state.right_half ? HALF_OFFSET : 20'h0;
   assign kanji_addr = kanji_base + half_add + {16'h0, state.line_index};
   assign ank_addr   = ANK_BASE + {8'h0, state.char_code[7:0], 4'b0000}
                       + {16'h0, state.line_index};

   // window decode from the updated state
   assign code = next_state.char_code;
   assign cls  = code[6:0];

   always_comb begin
      win_low  = NO_WINDOW;
      win_high = NO_WINDOW;
      writable = 1'b0;
      if (chip_level >= WINDOW_LEVEL) begin
         if (code[15:8] == 8'h00) begin
            // half-width codes
            win_high = ANK_BASE + {8'h0, code[7:0], 4'b0000}
                       + (mode_bit ? 20'h0 : MODE_OFFSET);
         end else begin
            win_high = {1'b0, code[14:8], 1'b0, code[6:0], 4'b0000};
            if (cls >= USER_LO && cls < USER_HI) begin
               writable = 1'b1;
               win_high = win_high + (next_state.right_half ? HALF_OFFSET : 20'h0);
            end else if ((cls >= SEMI_LO && cls < SEMI_HI) ||
                         (cls >= USER_HI && cls < RSV_HI)) begin
               win_high = win_high + (next_state.right_half ? HALF_OFFSET : 20'h0);
            end else if (cls < GAP_LO || cls >= SEMI_HI) begin
               // full-width: both halves
               win_low  = win_high;
               win_high = win_high + HALF_OFFSET;
            end
         end
      end
   end

   // result word in field order
   assign result = {font_access, font_addr, font_wdata, win_low[18:0], win_high,
                    writable, next_state.written_mark};

endmodule

[design/char_generator_port_decoder.sv]
// Top level of the character generator port decoder: state, config and output buffering.
// Depends on cgpd_pkg and cgpd_decode.
`timescale 1ns / 1ps
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, req_opcode, ...   | in
//  rsp     | rsp_valid, rsp_stall, rsp_font_*, ...   | out
//  csr     | csr_write_enable, csr_index, csr_write_data | in
//
//  One word per cycle while req_stall is low; each taken request's result is registered.
//  Decode is a single combinational pass between the port state and the output register.
//  A skid register behind the output register takes one word while rsp is stalled;
//  req_stall rises only when that skid register is full.
//  Synchronous reset clears code, line, half select, marks, config and valid flags.

module char_generator_port_decoder import cgpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_font_access,
   output logic [19:0] rsp_font_addr,
   output logic [7:0]  rsp_font_wdata,
   output logic [18:0] rsp_window_low,
   output logic [19:0] rsp_window_high,
   output logic        rsp_window_writable,
   output logic        rsp_pattern_written,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [1:0]  csr_write_data
);

   port_state_type state_ff, state_in;
   logic [1:0]     chip_level_ff;
   logic           mode_bit_ff;
   result_type     result;
   result_type     out_ff;
   result_type     skid_ff;
   logic           out_valid_ff;
   logic           skid_valid_ff;
   logic           req_take;
   logic           rsp_take;

   cgpd_decode u_decode (
      .state      (state_ff),
      .chip_level (chip_level_ff),
      .mode_bit   (mode_bit_ff),
      .opcode     (req_opcode),
      .data_byte  (req_data_byte),
      .next_state (state_in),
      .result     (result)
   );

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_level_ff <= '0;
         mode_bit_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CHIP_LEVEL: chip_level_ff <= csr_write_data;
            CSR_MODE_BIT:   mode_bit_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // port state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // output register and skid valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (out_valid_ff && !rsp_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output and skid payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_ff <= skid_ff;
         end
      end else if (req_take) begin
         if (out_valid_ff && !rsp_take) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_font_access     = out_ff.font_access;
   assign rsp_font_addr       = out_ff.font_addr;
   assign rsp_font_wdata      = out_ff.font_wdata;
   assign rsp_window_low      = out_ff.window_low;
   assign rsp_window_high     = out_ff.window_high;
   assign rsp_window_writable = out_ff.window_writable;
   assign rsp_pattern_written = out_ff.pattern_written;

endmodule

[tb/char_generator_port_decoder_tb.sv]
// Self-checking bench for the character generator port decoder: a scoreboard class
// predicts each result word from the bus accesses, and plain tasks drive the ports.
// Depends on cgpd_pkg and the char_generator_port_decoder RTL.
`timescale 1ns / 1ps

module char_generator_port_decoder_tb;
   import cgpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned WORDS_PER_PHASE = 290;
   localparam int unsigned PHASE_COUNT = 6;

   // predicts font requests and window decode, then checks result words in order
   class port_scoreboard;
      logic [1:0]  chip_level;
      logic        mode_bit;
      logic [15:0] char_code;
      logic [3:0]  line_index;
      logic        right_half;
      logic        written_mark;
      result_type  predicted_words[$];
      int unsigned mismatch_count;
      int unsigned checked_count;
      int unsigned stored_count;
      int unsigned read_count;

      function new();
         chip_level = '0;
         mode_bit = 1'b0;
         char_code = '0;
         line_index = '0;
         right_half = 1'b0;
         written_mark = 1'b0;
         mismatch_count = 0;
         checked_count = 0;
         stored_count = 0;
         read_count = 0;
      endfunction

      // address of the current line in the double-byte pattern area
      function logic [19:0] glyph_row_addr();
         logic [19:0] base;
         base = {4'd0, char_code & 16'h7f7f} << 4;
         return base + (right_half ? HALF_OFFSET : 20'd0) + {16'd0, line_index};
      endfunction

      // accepted bus access: update state and queue the word it yields
      function void predict_access(logic [2:0] op, logic [7:0] data);
         result_type  word;
         logic [19:0] low;
         logic [19:0] high;
         logic [6:0]  cls;
         logic [19:0] half;
         word = '0;
         case (op)
            OP_CODE_HIGH: char_code[15:8] = data;
            OP_CODE_LOW:  char_code[7:0] = data;
            OP_LINE: begin
               line_index = data[3:0];
               right_half = !data[5];
            end
            OP_PAT_WRITE: begin
               // only the user-definable code pair takes a pattern byte
               if (char_code[6:1] == USER_CODE) begin
                  word.font_access = ACC_WRITE;
                  word.font_addr = glyph_row_addr();
                  word.font_wdata = data;
                  written_mark = 1'b1;
                  stored_count++;
               end
            end
            OP_PAT_READ: begin
               word.font_access = ACC_READ;
               if (char_code[15:8] != 8'd0)
                  word.font_addr = glyph_row_addr();
               else
                  word.font_addr = ANK_BASE + {char_code, 4'd0} + {16'd0, line_index};
               read_count++;
            end
            default: ;
         endcase

         // window decode from the updated state and current settings
         low = NO_WINDOW;
         high = NO_WINDOW;
         half = right_half ? HALF_OFFSET : 20'd0;
         word.window_writable = 1'b0;
         if (chip_level >= WINDOW_LEVEL) begin
            if (char_code[15:8] == 8'd0) begin
               high = ANK_BASE + {char_code, 4'd0};
               if (!mode_bit)
                  high = high + MODE_OFFSET;
            end else begin
               cls = char_code[6:0];
               high = {4'd0, char_code & 16'h7f7f} << 4;
               if (cls >= USER_LO && cls < USER_HI) begin
                  word.window_writable = 1'b1;
                  high = high + half;
               end else if ((cls >= SEMI_LO && cls < SEMI_HI) ||
                            (cls >= USER_HI && cls < RSV_HI)) begin
                  high = high + half;
               end else if (cls < GAP_LO || cls >= SEMI_HI) begin
                  low = high;
                  high = high + HALF_OFFSET;
               end
            end
         end
         word.window_low = low[18:0];
         word.window_high = high;
         word.pattern_written = written_mark;
         predicted_words.push_back(word);
      endfunction

      // compare one accepted result word with the oldest prediction
      function void check_result(result_type got);
         result_type want;
         checked_count++;
         if (predicted_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result word with nothing outstanding: %h", $realtime, got);
            return;
         end
         want = predicted_words.pop_front();
         if (got.font_access !== want.font_access || got.font_addr !== want.font_addr ||
             got.font_wdata !== want.font_wdata || got.window_low !== want.window_low ||
             got.window_high !== want.window_high ||
             got.window_writable !== want.window_writable ||
             got.pattern_written !== want.pattern_written) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: word %0d mismatch", $realtime, checked_count);
               $display("   exp acc %0d addr %h wd %h lo %h hi %h wr %b pw %b",
                        want.font_access, want.font_addr, want.font_wdata, want.window_low,
                        want.window_high, want.window_writable, want.pattern_written);
               $display("   got acc %0d addr %h wd %h lo %h hi %h wr %b pw %b",
                        got.font_access, got.font_addr, got.font_wdata, got.window_low,
                        got.window_high, got.window_writable, got.pattern_written);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_font_access;
   logic [19:0] rsp_font_addr;
   logic [7:0]  rsp_font_wdata;
   logic [18:0] rsp_window_low;
   logic [19:0] rsp_window_high;
   logic        rsp_window_writable;
   logic        rsp_pattern_written;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [1:0]  csr_write_data = '0;

   port_scoreboard sb = new();
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned words_sent = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count = 0;

   char_generator_port_decoder i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_font_access     (rsp_font_access),
      .rsp_font_addr       (rsp_font_addr),
      .rsp_font_wdata      (rsp_font_wdata),
      .rsp_window_low      (rsp_window_low),
      .rsp_window_high     (rsp_window_high),
      .rsp_window_writable (rsp_window_writable),
      .rsp_pattern_written (rsp_pattern_written),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.predict_access(req_opcode, req_data_byte);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_font_access, rsp_font_addr, rsp_font_wdata, rsp_window_low,
                          rsp_window_high, rsp_window_writable, rsp_pattern_written});
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  sb.predicted_words.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // send one word, with a random gap first; starts and ends at a falling edge
   task automatic send_word(input logic [2:0] op, input logic [7:0] data);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // let every predicted word come back, then a short quiet spell
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.predicted_words.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write both registers while the port is idle
   task automatic set_config(input logic [1:0] level, input logic mode);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CHIP_LEVEL;
      csr_write_data <= level;
      @(negedge clock);
      csr_index <= CSR_MODE_BIT;
      csr_write_data <= {1'b0, mode};
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.chip_level = level;
      sb.mode_bit = mode;
      settings_used++;
   endtask

   // code low byte spread over the decode classes, bit 7 random
   function automatic logic [7:0] pick_code_low();
      logic [7:0] b;
      case ($urandom_range(4))
         0: b = 8'h56 + 8'($urandom_range(1));
         1: b = 8'h0c + 8'($urandom_range(3));
         2: b = 8'h58 + 8'($urandom_range(7));
         3: b = 8'h08 + 8'($urandom_range(3));
         default: b = 8'($urandom);
      endcase
      b[7] = 1'($urandom_range(1));
      return b;
   endfunction

   // mostly code / line setup followed by pattern accesses, some raw noise
   task automatic send_sequence();
      if ($urandom_range(99) < 70) begin
         if ($urandom_range(3) != 0)
            send_word(OP_CODE_HIGH, ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
         send_word(OP_CODE_LOW, pick_code_low());
         if ($urandom_range(1) != 0)
            send_word(OP_LINE, 8'($urandom));
         repeat ($urandom_range(1, 4))
            send_word(($urandom_range(1) != 0) ? OP_PAT_WRITE : OP_PAT_READ, 8'($urandom));
      end else begin
         send_word(3'($urandom_range(7)), 8'($urandom));
      end
   endtask

   initial begin
      logic [1:0]  phase_level[PHASE_COUNT];
      logic        phase_mode[PHASE_COUNT];
      int unsigned target;

      phase_level = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2};
      phase_mode  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: field extremes, every operation, code classes
      send_idle_pct = 14;
      recv_stall_pct = 54;
      set_config(2'd2, 1'b0);
      send_word(OP_PAT_READ, 8'h00);
      send_word(OP_LINE, 8'h00);
      send_word(OP_LINE, 8'hff);
      send_word(OP_CODE_LOW, 8'hff);
      send_word(OP_PAT_READ, 8'hff);
      send_word(OP_CODE_HIGH, 8'hff);
      send_word(OP_CODE_LOW, 8'h56);
      send_word(OP_PAT_WRITE, 8'ha5);
      send_word(OP_PAT_READ, 8'h00);
      send_word(OP_CODE_LOW, 8'hd7);
      send_word(OP_LINE, 8'hdf);
      send_word(OP_PAT_WRITE, 8'hff);
      send_word(OP_PAT_WRITE, 8'h00);
      send_word(OP_CODE_LOW, 8'h58);
      send_word(OP_PAT_WRITE, 8'h3c);
      send_word(OP_CODE_LOW, 8'h0c);
      send_word(OP_CODE_LOW, 8'h0a);
      send_word(OP_CODE_LOW, 8'h07);
      send_word(OP_CODE_LOW, 8'h60);
      send_word(3'd5, 8'hff);
      send_word(3'd6, 8'h00);
      send_word(3'd7, 8'hff);
      send_word(OP_CODE_HIGH, 8'h01);
      send_word(OP_PAT_READ, 8'h00);
      wait_for_results();

      // random phases over register settings and idle profiles
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p < 2) begin
            send_idle_pct = 14;
            recv_stall_pct = 54;
         end else if (p < 4) begin
            send_idle_pct = 54;
            recv_stall_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         set_config(phase_level[p], phase_mode[p]);
         target = words_sent + WORDS_PER_PHASE;
         while (words_sent < target)
            send_sequence();
         wait_for_results();
      end

      $display("sent %0d words over %0d register settings, checked %0d result words",
               words_sent, settings_used, sb.checked_count);
      $display("pattern bytes stored %0d, pattern reads %0d", sb.stored_count,
               sb.read_count);
      if (sb.mismatch_count == 0 && sb.predicted_words.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[char_generator_port_decoder.f]
design/cgpd_pkg.sv
design/cgpd_decode.sv
design/char_generator_port_decoder.sv
tb/char_generator_port_decoder_tb.sv
